### design/rrt_pkg.sv
`default_nettype none

package rrt_pkg;

  // Item opcodes
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  // Result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_DUP   = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;
  localparam logic [1:0] STATUS_EMPTY = 2'd3;

  // One stored mapping, as held in the table memory
  typedef struct packed {
    logic [31:0] span;
    logic [31:0] dest_start;
    logic [31:0] src_start;
  } map_entry_t;

  localparam int unsigned EntryW = $bits(map_entry_t);

endpackage

`default_nettype wire

### design/rrt_ram.sv
`default_nettype none

module rrt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic                  clk_i,
  input  wire logic                  we_i,
  input  wire logic [AddrW-1:0]      waddr_i,
  input  wire logic [Width-1:0]      wdata_i,
  input  wire logic                  re_i,
  input  wire logic [AddrW-1:0]      raddr_i,
  output logic      [Width-1:0]      rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### design/range_remap_table_top.sv
`default_nettype none

// Range remap table: holds up to ENTRIES mappings (source start, destination
// start, span) in one synchronous memory and serves one command word at a time.
// Input channel s_axis: tuser carries the opcode (clear, insert, lookup), tdata
// carries key, dest_start and span. Output channel m_axis: one result word per
// command, tdata is the value, tuser carries hit, overflow and status.
// Clear and the unused opcode go straight from the idle state to the done state.
// Insert and lookup scan the stored entries through the single read port of the
// table memory, one entry per cycle; a lookup stops early at the first matching
// entry and an insert at a stored copy of its source start.
// With an empty table, insert and lookup skip the scan and answer at once.
// Throughput: one command at a time; the next command is accepted as soon as
// the block is back in its idle state, even while the last result still
// waits in the output register.
// Reset empties the table at once (the entry count goes to zero); the memory
// contents are not cleared, and only entries below the count are ever read.
// When the receiver stalls, the finished result holds in the output register
// and a following command waits in its final state until that word is taken.

module range_remap_table_top
  import rrt_pkg::*;
#(
  parameter int unsigned ENTRIES = 64
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // Command channel
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [95:0]  s_axis_tdata,   // key[31:0], dest_start[63:32], span[95:64]
  input  wire logic [1:0]   s_axis_tuser,   // opcode[1:0]
  // Result channel
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [31:0]       m_axis_tdata,   // value[31:0]
  output logic [3:0]        m_axis_tuser    // hit[0], overflow[1], status[3:2]
);

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(ENTRIES + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CntW-1:0]  iss_q, iss_d;
  logic             chk_q, chk_d;
  logic             found_q, found_d;
  logic [1:0]       op_q;
  logic [31:0]      key_q, dst_q, span_q;
  logic [31:0]      ofs_q, ofs_d;
  logic [31:0]      mdst_q, mdst_d;
  logic             out_vld_q, out_vld_d;
  logic [31:0]      out_val_q, out_val_d;
  logic [3:0]       out_usr_q, out_usr_d;

  logic             in_acc;
  logic             out_free;
  logic             ram_re, ram_we;
  logic [IdxW-1:0]  ram_raddr, ram_waddr;
  map_entry_t       ram_wdata, ram_rdata;
  logic             match_now;
  logic [31:0]      key_ofs;
  logic [32:0]      sum;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_vld_q || m_axis_tready;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_val_q;
  assign m_axis_tuser  = out_usr_q;

  // Table memory
  rrt_ram #(
    .Width (EntryW),
    .Depth (ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Compare the entry read last cycle against the held key
  assign key_ofs = key_q - ram_rdata.src_start;
  always_comb begin
    match_now = 1'b0;
    if (chk_q) begin
      if (op_q == OP_INSERT) begin
        match_now = (ram_rdata.src_start == key_q);
      end else begin
        match_now = (key_q >= ram_rdata.src_start) && (key_ofs < ram_rdata.span);
      end
    end
  end

  assign sum = {1'b0, mdst_q} + {1'b0, ofs_q};

  // Issue reads and append on insert
  assign ram_re    = (state_q == ST_SCAN) && (iss_q != cnt_q) && !match_now;
  assign ram_raddr = iss_q[IdxW-1:0];
  assign ram_waddr = cnt_q[IdxW-1:0];
  assign ram_wdata = '{span: span_q, dest_start: dst_q, src_start: key_q};
  assign ram_we    = (state_q == ST_DONE) && out_free && (op_q == OP_INSERT) &&
                     !found_q && (cnt_q != CntW'(ENTRIES));

  // Sequencer
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    iss_d     = iss_q;
    chk_d     = 1'b0;
    found_d   = found_q;
    ofs_d     = ofs_q;
    mdst_d    = mdst_q;
    out_vld_d = out_vld_q && !m_axis_tready;
    out_val_d = out_val_q;
    out_usr_d = out_usr_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          iss_d   = '0;
          found_d = 1'b0;
          if (s_axis_tuser == OP_CLEAR) begin
            cnt_d   = '0;
            state_d = ST_DONE;
          end else if ((s_axis_tuser == OP_INSERT || s_axis_tuser == OP_LOOKUP) &&
                       (cnt_q != '0)) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        chk_d = ram_re;
        if (ram_re) begin
          iss_d = iss_q + 1'b1;
        end
        if (match_now) begin
          found_d = 1'b1;
          ofs_d   = key_ofs;
          mdst_d  = ram_rdata.dest_start;
          state_d = ST_DONE;
        end else if (iss_q == cnt_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          out_val_d = '0;
          out_usr_d = {STATUS_OK, 1'b0, 1'b0};
          unique case (op_q)
            OP_INSERT: begin
              if (found_q) begin
                out_usr_d = {STATUS_DUP, 1'b0, 1'b0};
              end else if (cnt_q == CntW'(ENTRIES)) begin
                out_usr_d = {STATUS_FULL, 1'b0, 1'b0};
              end else begin
                cnt_d = cnt_q + 1'b1;
              end
            end
            OP_LOOKUP: begin
              out_val_d = key_q;
              if (cnt_q == '0) begin
                out_usr_d = {STATUS_EMPTY, 1'b0, 1'b0};
              end else if (found_q) begin
                out_val_d = sum[31:0];
                out_usr_d = {STATUS_OK, sum[32], 1'b1};
              end
            end
            default: begin
            end
          endcase
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      iss_q     <= '0;
      chk_q     <= 1'b0;
      found_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      iss_q     <= iss_d;
      chk_q     <= chk_d;
      found_q   <= found_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= s_axis_tuser;
      key_q  <= s_axis_tdata[31:0];
      dst_q  <= s_axis_tdata[63:32];
      span_q <= s_axis_tdata[95:64];
    end
    ofs_q     <= ofs_d;
    mdst_q    <= mdst_d;
    out_val_q <= out_val_d;
    out_usr_q <= out_usr_d;
  end

  // Checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(ENTRIES))
    else $error("entry count past table depth");

  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> !ram_we)
    else $error("table write during scan");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tuser == OP_CLEAR) |=> (cnt_q == '0))
    else $error("clear left entries in the table");

  a_ovf_needs_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_usr_q[1]) |-> (out_usr_q[0] && out_usr_q[3:2] == STATUS_OK))
    else $error("overflow flagged without a hit");

endmodule

`default_nettype wire

### bench/range_remap_table_top_tb.sv
`default_nettype none

module range_remap_table_top_tb;
  import rrt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ENTRIES    = 64;
  localparam int          ITEMS      = 550;
  localparam int          IDLE_LIMIT = 4000;
  localparam int          DRAIN_CYC  = ENTRIES + 16;
  localparam int          STALL_LONG = 300;

  // Opcode with no function: the block answers with an all-zero word
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] key;
    logic [31:0] dst;
    logic [31:0] span;
  } remap_cmd_t;

  typedef struct packed {
    logic [31:0] value;
    logic        hit;
    logic        ovf;
    logic [1:0]  status;
  } remap_res_t;

  typedef struct packed {
    remap_cmd_t cmd;
    logic       typed;
    remap_res_t res;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata;   // key[31:0], dest_start[63:32], span[95:64]
  logic [1:0]  s_axis_tuser;   // opcode[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // value[31:0]
  logic [3:0]  m_axis_tuser;   // hit[0], overflow[1], status[3:2]

  // Shadow copy of the mapping store
  logic [31:0] map_src  [ENTRIES];
  logic [31:0] map_dst  [ENTRIES];
  logic [31:0] map_span [ENTRIES];
  int unsigned map_cnt;

  remap_res_t  remap_due_q [$];
  dir_row_t    dir_rows    [$];
  int          words_in;
  int          fail_cnt;
  bit          no_idle;

  range_remap_table_top #(
    .ENTRIES(ENTRIES)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Apply one command to the shadow table and return the word it yields
  function automatic remap_res_t remap_apply(remap_cmd_t c);
    remap_res_t  r;
    logic [32:0] sum;
    logic [31:0] offs;
    bit          dup;
    r   = '0;
    dup = 1'b0;
    case (c.op)
      OP_CLEAR: begin
        map_cnt = 0;
      end
      OP_INSERT: begin
        for (int i = 0; i < map_cnt; i++) begin
          if (map_src[i] == c.key) dup = 1'b1;
        end
        if (dup) begin
          r.status = STATUS_DUP;
        end else if (map_cnt >= ENTRIES) begin
          r.status = STATUS_FULL;
        end else begin
          map_src[map_cnt]  = c.key;
          map_dst[map_cnt]  = c.dst;
          map_span[map_cnt] = c.span;
          map_cnt++;
        end
      end
      OP_LOOKUP: begin
        r.value = c.key;
        if (map_cnt == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          // Earliest stored range holding the key wins
          for (int i = 0; i < map_cnt; i++) begin
            offs = c.key - map_src[i];
            if (!r.hit && c.key >= map_src[i] && offs < map_span[i]) begin
              sum     = {1'b0, map_dst[i]} + {1'b0, offs};
              r.value = sum[31:0];
              r.ovf   = sum[32];
              r.hit   = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Offer one command word, wait for the handshake, queue its expected result
  task automatic send_cmd(input remap_cmd_t c, input logic typed, input remap_res_t tres);
    int r;
    int gap;
    remap_res_t pres;
    r   = $urandom_range(0, 99);
    gap = 0;
    if (!no_idle) begin
      if (r >= 92) gap = $urandom_range(10, 40);
      else if (r >= 60) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {c.span, c.dst, c.key};
    s_axis_tuser  <= c.op;
    do @(posedge clk_i); while (!s_axis_tready);
    pres = remap_apply(c);
    remap_due_q.push_back(typed ? tres : pres);
    words_in++;
  endtask

  task automatic add_row(input logic [1:0] op, input logic [31:0] key, input logic [31:0] dst,
                         input logic [31:0] span, input logic typed,
                         input logic [31:0] value, input logic [1:0] status);
    dir_row_t row;
    row.cmd        = '{op: op, key: key, dst: dst, span: span};
    row.typed      = typed;
    row.res        = '0;
    row.res.value  = value;
    row.res.status = status;
    dir_rows.push_back(row);
  endtask

  // Result side: compare each word with the oldest expectation, stall at random
  initial begin
    int         r;
    int         hold;
    bit         pressure_done;
    remap_res_t got;
    remap_res_t want;
    hold          = 0;
    pressure_done = 1'b0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        got = '{value: m_axis_tdata, hit: m_axis_tuser[0], ovf: m_axis_tuser[1],
                status: m_axis_tuser[3:2]};
        if (remap_due_q.size() == 0) begin
          $display("%0t: unexpected result word: got value=%h hit=%b ovf=%b status=%0d",
                   $time, got.value, got.hit, got.ovf, got.status);
          fail_cnt++;
        end else begin
          want = remap_due_q.pop_front();
          if (got !== want) begin
            $display({"%0t: result mismatch: expected value=%h hit=%b ovf=%b status=%0d,",
                      " got value=%h hit=%b ovf=%b status=%0d"},
                     $time, want.value, want.hit, want.ovf, want.status,
                     got.value, got.hit, got.ovf, got.status);
            fail_cnt++;
          end
        end
      end
      // One long hold-off so the block backs up and stalls its input
      if (!pressure_done && words_in >= 120) begin
        pressure_done = 1'b1;
        hold          = STALL_LONG;
      end
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else if (no_idle) begin
        m_axis_tready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 75) begin
          m_axis_tready <= 1'b1;
        end else begin
          m_axis_tready <= 1'b0;
          hold = (r < 96) ? $urandom_range(0, 3) : $urandom_range(15, 50);
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle = 0;
      end else begin
        idle++;
        if (idle >= IDLE_LIMIT) begin
          $display("%0t: no word accepted for %0d cycles", $time, IDLE_LIMIT);
          $display("[FAIL] regression broken");
          $finish;
        end
      end
    end
  end

  // Stimulus: directed rows, then random phases of fills and lookups
  initial begin
    remap_cmd_t c;
    int         phase;
    int         fill;
    int         steps;
    int         ins_left;
    int         r;
    int         r2;
    int         idx;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    map_cnt  = 0;
    words_in = 0;
    fail_cnt = 0;
    no_idle  = 1'b0;

    // Empty table, unused opcode, clear on empty, duplicates and range edges
    add_row(OP_LOOKUP, '1, '1, '1, 1'b1, 32'hFFFF_FFFF, STATUS_EMPTY);
    add_row(OP_UNUSED, '1, '1, '1, 1'b1, '0, STATUS_OK);
    add_row(OP_CLEAR, '1, '1, '1, 1'b1, '0, STATUS_OK);
    add_row(OP_INSERT, 32'h0, 32'hFFFF_FFF0, 32'h100, 1'b1, '0, STATUS_OK);
    add_row(OP_INSERT, 32'h0, 32'h1, 32'h1, 1'b1, '0, STATUS_DUP);
    add_row(OP_LOOKUP, 32'h0, '0, '0, 1'b0, '0, STATUS_OK);
    add_row(OP_LOOKUP, 32'h20, '0, '0, 1'b0, '0, STATUS_OK);
    add_row(OP_LOOKUP, 32'hFF, '1, '1, 1'b0, '0, STATUS_OK);
    add_row(OP_LOOKUP, 32'h100, '0, '0, 1'b0, '0, STATUS_OK);
    // Range that runs past the top of the key space
    add_row(OP_INSERT, 32'hFFFF_FF00, 32'h1000, 32'hFFFF_FFFF, 1'b1, '0, STATUS_OK);
    add_row(OP_LOOKUP, 32'hFFFF_FFFF, '0, '0, 1'b0, '0, STATUS_OK);
    add_row(OP_LOOKUP, 32'hFFFF_FEFF, '0, '0, 1'b0, '0, STATUS_OK);
    // Zero span never matches
    add_row(OP_INSERT, 32'h1000, 32'h5, 32'h0, 1'b1, '0, STATUS_OK);
    add_row(OP_LOOKUP, 32'h1000, '0, '0, 1'b0, '0, STATUS_OK);
    // Overlap with the first range: the earlier insert wins
    add_row(OP_INSERT, 32'h10, 32'hAAAA_0000, 32'h10, 1'b1, '0, STATUS_OK);
    add_row(OP_LOOKUP, 32'h18, '0, '0, 1'b0, '0, STATUS_OK);
    add_row(OP_INSERT, 32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1, '0, STATUS_OK);
    add_row(OP_LOOKUP, 32'hC000_0000, '0, '0, 1'b0, '0, STATUS_OK);
    add_row(OP_UNUSED, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678, 1'b1, '0, STATUS_OK);
    add_row(OP_CLEAR, 32'h0, 32'h0, 32'h0, 1'b1, '0, STATUS_OK);
    add_row(OP_LOOKUP, 32'h1234_5678, '0, '0, 1'b1, 32'h1234_5678, STATUS_EMPTY);
    add_row(OP_INSERT, 32'hFFFF_FFFF, 32'h0, 32'h1, 1'b1, '0, STATUS_OK);
    add_row(OP_LOOKUP, 32'hFFFF_FFFF, '0, '0, 1'b0, '0, STATUS_OK);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      send_cmd(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].res);
    end

    phase = 0;
    while (words_in < ITEMS) begin
      no_idle  = ($urandom_range(0, 4) == 0);
      fill     = (phase == 1 || $urandom_range(0, 15) == 0) ?
                 ENTRIES + $urandom_range(1, 5) : $urandom_range(1, 12);
      ins_left = fill;
      steps    = 2 * fill + $urandom_range(2, 10);
      if ($urandom_range(0, 4) != 0) begin
        c = '{op: OP_CLEAR, key: $urandom, dst: $urandom, span: $urandom};
        send_cmd(c, 1'b0, '0);
      end
      for (int s = 0; s < steps && words_in < ITEMS; s++) begin
        r  = $urandom_range(0, 99);
        r2 = $urandom_range(0, 99);
        c  = '{op: OP_LOOKUP, key: $urandom, dst: $urandom, span: $urandom};
        if (r >= 95) begin
          // Noise: unused opcode, or a clear that breaks the sequence
          c.op = (r2 < 70) ? OP_UNUSED : OP_CLEAR;
        end else if (ins_left > 0 && r < 50) begin
          ins_left--;
          c.op = OP_INSERT;
          if (map_cnt > 0 && r2 < 10) c.key = map_src[$urandom_range(0, map_cnt - 1)];
          if ($urandom_range(0, 99) < 20) c.dst = 32'hFFFF_FFFF - $urandom_range(0, 255);
          r2 = $urandom_range(0, 99);
          if (r2 < 8) c.span = '0;
          else if (r2 >= 20) c.span = $urandom_range(1, 4096);
        end else if (map_cnt > 0 && r2 >= 20) begin
          // Aim the lookup at a stored range: inside it, or on its edges
          idx = $urandom_range(0, map_cnt - 1);
          r2  = $urandom_range(0, 99);
          if (map_span[idx] == 0 || r2 < 15) c.key = map_src[idx];
          else if (r2 < 60) c.key = map_src[idx] + ($urandom % map_span[idx]);
          else if (r2 < 80) c.key = map_src[idx] + map_span[idx] - 1;
          else c.key = map_src[idx] + map_span[idx];
        end
        send_cmd(c, 1'b0, '0);
      end
      phase++;
    end
    s_axis_tvalid <= 1'b0;
    no_idle = 1'b0;

    // Drain outstanding results, then allow time for stray words
    while (remap_due_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);

    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
design/rrt_pkg.sv
design/rrt_ram.sv
design/range_remap_table_top.sv
bench/range_remap_table_top_tb.sv
